>>> design/prlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlb_pkg
// Types and constants shared by the particle ring lifetime burst block.
// ----------------------------------------------------------------------------
package prlb_pkg;

    localparam int OUT_W     = 5;
    localparam int LT_W      = 24;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int RND_W     = 16;
    localparam int CFG_CNT_W = 5;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_LEVEL = 2'd1;
    localparam logic [OP_W-1:0] OP_ACTIVATE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_COUNT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_VARIATION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LIFETIME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LIFETIME = 2'd3;

    localparam logic [CFG_CNT_W-1:0] BASE_COUNT_RESET      = 5'd5;
    localparam logic [CFG_CNT_W-1:0] COUNT_VARIATION_RESET = 5'd2;
    localparam logic [LT_W-1:0]      MAX_LIFETIME_RESET    = 24'd196608;
    localparam logic [LT_W-1:0]      DEFAULT_LIFETIME_RESET = 24'd0;
    localparam logic [LT_W-1:0]      LT_SAT                = 24'hFFFFFF;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic signed [LT_W-1:0] delta_time;
        logic                   level;
        logic [RND_W-1:0]       random_frac;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] oldest_index;
        logic [OUT_W-1:0] next_free_index;
        logic [OUT_W-1:0] live_count;
        logic [OUT_W-1:0] spawned_count;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic walk_rd;
        logic walk_wr;
        logic spawn_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_is_tick;
        logic walk_done;
        logic tick_spawn;
        logic spawn_done;
        logic out_free;
    } status_t;

endpackage

>>> design/prlb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module prlb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/prlb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlb_ctrl
// Sequencer for the aging walk, the spawn burst and the result handoff.
// ----------------------------------------------------------------------------
module prlb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prlb_pkg::status_t status,
    output prlb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_WR,
        S_SPAWN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = status.in_is_tick ? S_WALK_RD : S_DONE;
                end
            end
            S_WALK_RD:
            begin
                if (status.walk_done)
                begin
                    state_next = status.tick_spawn ? S_SPAWN : S_DONE;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_WR;
                end
            end
            S_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = S_WALK_RD;
            end
            S_SPAWN:
            begin
                if (status.spawn_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.spawn_wr = 1'b1;
                end
            end
            S_DONE:
            begin
                cmd.finish = status.out_free;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // A write of the walk always follows the read of the same entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_wr |-> $past(cmd.walk_rd))
        else $error("walk write without preceding read");

    // Only one datapath command is issued per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.walk_rd, cmd.walk_wr, cmd.spawn_wr, cmd.finish}))
        else $error("more than one datapath command");

    // The spawn burst is only entered when the level showed a rising edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD && status.walk_done && !status.tick_spawn)
        |=> state_reg == S_DONE)
        else $error("spawn entered without a rising level");

endmodule

>>> design/prlb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prlb_dp
// Datapath: lifetime ring, pointers, levels, settings and result register.
// ----------------------------------------------------------------------------
module prlb_dp #(
    parameter int RING_DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  prlb_pkg::in_item_t                     in_data,
    input  logic                                   cfg_valid,
    input  logic [prlb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [prlb_pkg::LT_W-1:0]              cfg_data,
    input  prlb_pkg::cmd_t                         cmd,
    output prlb_pkg::status_t                      status,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output prlb_pkg::out_item_t                    out_data
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int OW = prlb_pkg::OUT_W;
    localparam int LW = prlb_pkg::LT_W;
    localparam int CW = prlb_pkg::CNT_W;
    localparam int SW = prlb_pkg::LT_W + 2;
    localparam int PRW = prlb_pkg::RND_W + prlb_pkg::CFG_CNT_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);

    logic [prlb_pkg::CFG_CNT_W-1:0] base_reg;
    logic [prlb_pkg::CFG_CNT_W-1:0] var_reg;
    logic [LW-1:0]                  max_reg;
    logic [LW-1:0]                  dflt_reg;

    logic [PW-1:0] oldest_reg;
    logic [PW-1:0] free_reg;
    logic [PW-1:0] walk_reg;
    logic          active_reg;
    logic          last_reg;

    logic [prlb_pkg::OP_W-1:0] op_reg;
    logic                      level_reg;
    logic signed [LW-1:0]      dt_reg;
    logic [CW-1:0]             want_reg;
    logic [CW-1:0]             made_reg;

    logic                 out_valid_reg;
    prlb_pkg::out_item_t  out_data_reg;

    logic [PRW-1:0]       prod;
    logic [CW-1:0]        want_next;
    logic [PW-1:0]        walk_succ;
    logic [PW-1:0]        free_succ;
    logic [LW-1:0]        ram_rdata;
    logic signed [SW-1:0] sum;
    logic [LW-1:0]        clamped;
    logic                 expired;
    logic                 ram_we;
    logic [PW-1:0]        ram_waddr;
    logic [LW-1:0]        ram_wdata;
    logic [PW:0]          diff;
    logic [PW:0]          live;

    assign prod      = PRW'(in_data.random_frac) * PRW'(var_reg);
    assign want_next = CW'(base_reg) + CW'(prod[PRW-1:prlb_pkg::RND_W]);

    assign walk_succ = (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
    assign free_succ = (free_reg == LAST_IDX) ? '0 : free_reg + 1'b1;

    assign sum     = $signed({2'b00, ram_rdata}) + $signed({{2{dt_reg[LW-1]}}, dt_reg});
    assign expired = (sum >= $signed({2'b00, max_reg}));

    always_comb
    begin
        if (sum[SW-1])
        begin
            clamped = '0;
        end
        else if (sum[SW-2])
        begin
            clamped = prlb_pkg::LT_SAT;
        end
        else
        begin
            clamped = sum[LW-1:0];
        end
    end

    assign ram_we    = cmd.walk_wr | cmd.spawn_wr;
    assign ram_waddr = cmd.walk_wr ? walk_reg : free_reg;
    assign ram_wdata = cmd.walk_wr ? clamped : dflt_reg;

    prlb_ram #(
        .WIDTH (LW),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.walk_rd),
        .raddr (walk_reg),
        .rdata (ram_rdata)
    );

    assign diff = {1'b0, free_reg} - {1'b0, oldest_reg};
    assign live = diff[PW] ? diff + (PW+1)'(RING_DEPTH) : diff;

    assign status.in_is_tick = (in_data.op == prlb_pkg::OP_TICK);
    assign status.walk_done  = (walk_reg == free_reg);
    assign status.tick_spawn = active_reg & ~last_reg;
    assign status.spawn_done = (made_reg >= want_reg) || (free_succ == oldest_reg);
    assign status.out_free   = ~out_valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= prlb_pkg::BASE_COUNT_RESET;
            var_reg       <= prlb_pkg::COUNT_VARIATION_RESET;
            max_reg       <= prlb_pkg::MAX_LIFETIME_RESET;
            dflt_reg      <= prlb_pkg::DEFAULT_LIFETIME_RESET;
            oldest_reg    <= '0;
            free_reg      <= '0;
            walk_reg      <= '0;
            active_reg    <= 1'b0;
            last_reg      <= 1'b0;
            made_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    prlb_pkg::REG_BASE_COUNT:       base_reg <= cfg_data[prlb_pkg::CFG_CNT_W-1:0];
                    prlb_pkg::REG_COUNT_VARIATION:  var_reg  <= cfg_data[prlb_pkg::CFG_CNT_W-1:0];
                    prlb_pkg::REG_MAX_LIFETIME:     max_reg  <= cfg_data;
                    prlb_pkg::REG_DEFAULT_LIFETIME: dflt_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.load)
            begin
                walk_reg <= oldest_reg;
                made_reg <= '0;
            end

            if (cmd.walk_wr)
            begin
                walk_reg <= walk_succ;
                if (expired)
                begin
                    oldest_reg <= walk_succ;
                end
            end

            if (cmd.spawn_wr)
            begin
                free_reg <= free_succ;
                made_reg <= made_reg + 1'b1;
            end

            if (cmd.finish)
            begin
                case (op_reg)
                    prlb_pkg::OP_TICK:      last_reg   <= active_reg;
                    prlb_pkg::OP_SET_LEVEL: active_reg <= level_reg;
                    prlb_pkg::OP_ACTIVATE:
                    begin
                        active_reg <= 1'b1;
                        last_reg   <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_data.op;
            level_reg <= in_data.level;
            dt_reg    <= in_data.delta_time;
            want_reg  <= want_next;
        end
        if (cmd.finish)
        begin
            out_data_reg.oldest_index    <= OW'(oldest_reg);
            out_data_reg.next_free_index <= OW'(free_reg);
            out_data_reg.live_count      <= OW'(live);
            out_data_reg.spawned_count   <= OW'(made_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A spawned entry never takes the last empty slot of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.spawn_wr |-> free_succ != oldest_reg)
        else $error("spawn would fill the last empty slot");

    // Both ring pointers stay inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= LAST_IDX && free_reg <= LAST_IDX)
        else $error("ring pointer out of range");

    // A new result is only loaded once the previous one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

>>> design/particle_ring_lifetime_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_ring_lifetime_burst
// Ring pool of particle lifetimes with aging, expiry and burst spawning.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. A set-level or activate
// item, or an unused op code, goes from acceptance straight to its result
// step, which loads the result once the output register is free. A tick
// first walks the live entries from the oldest on: the single lifetime
// memory is read and then written once per live entry. When the active
// level shows a rising edge the tick then spawns new entries, one memory
// write each, before its result step. The next item is accepted in the cycle
// after a result is loaded, even while that result still waits in the output
// register; a following item then stalls in its last step until the waiting
// result is taken. The configuration port is always ready and is to be
// written only while the block is idle.
module particle_ring_lifetime_burst #(
    parameter int RING_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  prlb_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output prlb_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [prlb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prlb_pkg::LT_W-1:0]      cfg_data
);

    prlb_pkg::cmd_t    cmd;
    prlb_pkg::status_t status;

    assign cfg_ready = 1'b1;

    prlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    prlb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
